/* rtl/localization_health_mode_supervisor_assert.svh */
// assertion macros used by the supervisor top level
`ifndef LOCALIZATION_HEALTH_MODE_SUPERVISOR_ASSERT_SVH
`define LOCALIZATION_HEALTH_MODE_SUPERVISOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define LHMS_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("supervisor check failed");
// next-cycle implication, disabled in reset
`define LHMS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("supervisor check failed");
`else
`define LHMS_ASSERT_NOW(label, clk, rst, cond, prop)
`define LHMS_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

/* rtl/lhms_pkg.sv */
// types, codes and reset values for the localization health supervisor
package lhms_pkg;

  // mode codes
  localparam logic [2:0] MODE_UNINIT   = 3'd0;
  localparam logic [2:0] MODE_NOMINAL  = 3'd1;
  localparam logic [2:0] MODE_DEGRADED = 3'd2;
  localparam logic [2:0] MODE_DEADRECK = 3'd3;
  localparam logic [2:0] MODE_FAULT    = 3'd4;

  // reason codes
  localparam logic [3:0] WHY_LATCHED     = 4'd0;
  localparam logic [3:0] WHY_INTEGRITY   = 4'd1;
  localparam logic [3:0] WHY_NOMINAL     = 4'd2;
  localparam logic [3:0] WHY_WAITING     = 4'd3;
  localparam logic [3:0] WHY_GAP         = 4'd4;
  localparam logic [3:0] WHY_ONE_BOARD   = 4'd5;
  localparam logic [3:0] WHY_ALIKE       = 4'd6;
  localparam logic [3:0] WHY_NONE        = 4'd7;
  localparam logic [3:0] WHY_OVER_BUDGET = 4'd8;

  // opcodes
  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BOARDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPREAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_BUDGET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DR_BUDGET   = 3'd4;

  // register reset values
  localparam logic [4:0]  RST_MIN_BOARDS = 5'd2;
  localparam logic [14:0] RST_MIN_SPREAD = 15'd1500;
  localparam logic [31:0] RST_GRACE      = 32'd500;
  localparam logic [31:0] RST_DEG_BUDGET = 32'd10000;
  localparam logic [31:0] RST_DR_BUDGET  = 32'd3000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic        solved;
    logic [7:0]  board_count;
    logic [14:0] spread_centideg;
    logic        integ_fail;
  } in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        request_stop;
    logic [3:0]  reason_code;
    logic [31:0] elapsed_ms;
    logic [31:0] budget_ms;
  } out_t;

  typedef struct packed {
    logic [4:0]  min_boards_for_nominal;
    logic [14:0] min_spread_centideg;
    logic [31:0] grace_ms;
    logic [31:0] degraded_budget_ms;
    logic [31:0] dead_reckon_budget_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] last_stamp;
    logic        stamp_valid;
    logic [31:0] since_good;
  } state_t;

endpackage

/* rtl/localization_health_mode_supervisor.sv */
// top level of the localization health mode supervisor
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data   (lhms_pkg::in_t)
//  out     | output    | out_valid/out_stall | out_data  (lhms_pkg::out_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low; a window's result passes
// through the input register, then the result register
// a restart beat updates state in the stage and produces no output beat
// rst is synchronous: mode uninitialized, timestamp invalid, registers at defaults
// out_stall holds the result register; the stage stalls input only when a
// window in it cannot pass to a full, stalled result register
module localization_health_mode_supervisor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lhms_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lhms_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [lhms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import lhms_pkg::*;
`include "localization_health_mode_supervisor_assert.svh"

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  in_t    stage;
  logic   stage_valid;
  out_t   res;
  logic   has_res;
  logic   out_free;
  logic   stage_fire;
  logic   in_accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_boards_for_nominal <= RST_MIN_BOARDS;
      cfg.min_spread_centideg    <= RST_MIN_SPREAD;
      cfg.grace_ms               <= RST_GRACE;
      cfg.degraded_budget_ms     <= RST_DEG_BUDGET;
      cfg.dead_reckon_budget_ms  <= RST_DR_BUDGET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_BOARDS: cfg.min_boards_for_nominal <= cfg_data[4:0];
        REG_MIN_SPREAD: cfg.min_spread_centideg    <= cfg_data[14:0];
        REG_GRACE:      cfg.grace_ms               <= cfg_data;
        REG_DEG_BUDGET: cfg.degraded_budget_ms     <= cfg_data;
        REG_DR_BUDGET:  cfg.dead_reckon_budget_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_free   = !out_valid || !out_stall;
  assign stage_fire = stage_valid && (!has_res || out_free);
  assign in_stall   = stage_valid && !stage_fire;
  assign in_accept  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage <= in_data;
    end
  end

  // update logic
  lhms_update u_update (
    .cfg     (cfg),
    .st      (st),
    .item    (stage),
    .st_next (st_next),
    .res     (res),
    .has_res (has_res)
  );

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (stage_fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && has_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && has_res) begin
      out_data <= res;
    end
  end

  // checks
  `LHMS_ASSERT_NEXT(a_fault_latched, clk, rst, stage_fire && has_res && (st.mode == MODE_FAULT), st.mode == MODE_FAULT)
  `LHMS_ASSERT_NEXT(a_restart_clears, clk, rst, stage_fire && !has_res, (st.mode == MODE_UNINIT) && (st.since_good == '0) && !st.stamp_valid)
  `LHMS_ASSERT_NOW(a_stop_iff_fault, clk, rst, out_valid, out_data.request_stop == (out_data.mode == MODE_FAULT))
  `LHMS_ASSERT_NOW(a_stall_needs_busy, clk, rst, in_stall, stage_valid && has_res && out_valid && out_stall)

endmodule

/* rtl/lhms_update.sv */
// one-window mode update: next supervisor state and the result beat
module lhms_update (
  input  lhms_pkg::cfg_t   cfg,
  input  lhms_pkg::state_t st,
  input  lhms_pkg::in_t    item,
  output lhms_pkg::state_t st_next,
  output lhms_pkg::out_t   res,
  output logic             has_res
);
  import lhms_pkg::*;

  logic [31:0] dt;
  logic [32:0] sum;
  logic [31:0] acc;
  logic        good;
  logic        few_boards;
  logic [31:0] budget;

  // time step, clamped at zero on first report or backwards stamp
  always_comb begin
    if (st.stamp_valid && (item.now_ms > st.last_stamp)) begin
      dt = item.now_ms - st.last_stamp;
    end else begin
      dt = '0;
    end
  end

  // saturating accumulate of time since good fix
  assign sum = {1'b0, st.since_good} + {1'b0, dt};
  assign acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign few_boards = item.board_count < {3'b000, cfg.min_boards_for_nominal};
  assign good = item.solved && !few_boards
                && (item.spread_centideg >= cfg.min_spread_centideg);
  assign budget = item.solved ? cfg.degraded_budget_ms : cfg.dead_reckon_budget_ms;

  // mode decision in priority order
  always_comb begin
    st_next = st;
    res     = '0;
    has_res = 1'b1;
    if (item.opcode == OP_RESTART) begin
      st_next.mode        = MODE_UNINIT;
      st_next.since_good  = '0;
      st_next.stamp_valid = 1'b0;
      has_res             = 1'b0;
    end else begin
      st_next.last_stamp  = item.now_ms;
      st_next.stamp_valid = 1'b1;
      priority if (st.mode == MODE_FAULT) begin
        res.mode         = MODE_FAULT;
        res.request_stop = 1'b1;
        res.reason_code  = WHY_LATCHED;
      end else if (item.integ_fail) begin
        st_next.mode     = MODE_FAULT;
        res.mode         = MODE_FAULT;
        res.request_stop = 1'b1;
        res.reason_code  = WHY_INTEGRITY;
      end else if (good) begin
        st_next.mode       = MODE_NOMINAL;
        st_next.since_good = '0;
        res.mode           = MODE_NOMINAL;
        res.reason_code    = WHY_NOMINAL;
      end else if ((st.mode == MODE_UNINIT) && !item.solved) begin
        res.mode        = MODE_UNINIT;
        res.reason_code = WHY_WAITING;
      end else if (!item.solved && (acc <= cfg.grace_ms) && (st.mode != MODE_UNINIT)) begin
        // empty window inside grace holds the previous mode
        st_next.since_good = acc;
        res.mode           = st.mode;
        res.reason_code    = WHY_GAP;
        res.elapsed_ms     = acc;
      end else if (acc > budget) begin
        st_next.since_good = acc;
        st_next.mode       = MODE_FAULT;
        res.mode           = MODE_FAULT;
        res.request_stop   = 1'b1;
        res.reason_code    = WHY_OVER_BUDGET;
        res.elapsed_ms     = acc;
        res.budget_ms      = budget;
      end else begin
        st_next.since_good = acc;
        st_next.mode       = item.solved ? MODE_DEGRADED : MODE_DEADRECK;
        res.mode           = st_next.mode;
        res.reason_code    = item.solved ? (few_boards ? WHY_ONE_BOARD : WHY_ALIKE)
                                         : WHY_NONE;
        res.elapsed_ms     = acc;
        res.budget_ms      = budget;
      end
    end
  end

endmodule

/* tb/sv/localization_health_mode_supervisor_tb.sv */
// self-checking testbench for the localization health mode supervisor
module localization_health_mode_supervisor_tb;
  import lhms_pkg::*;

  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 272;
  localparam int DRAIN_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam out_t NO_REPORT = '0;

  typedef struct {
    bit   wide;
    in_t  beat;
    bit   typed;
    out_t want;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // expected health reports, oldest first
  out_t pending_health[$];
  row_t directed_rows[$];
  int fail_count = 0;

  // tracked supervisor state and settings
  cfg_t        track_cfg;
  logic [2:0]  track_mode;
  logic [31:0] track_stamp;
  logic        track_stamp_ok;
  logic [31:0] track_since_fix;

  logic [31:0] stamp_cursor;
  out_t due_report;
  int   stall_left = 0;
  int   quiet_left = 0;
  bit   stall_quiet = 0;

  localization_health_mode_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic out_t health(logic [2:0] m, logic stop, logic [3:0] why,
                                  logic [31:0] elapsed, logic [31:0] budget);
    out_t r;
    r.mode = m;
    r.request_stop = stop;
    r.reason_code = why;
    r.elapsed_ms = elapsed;
    r.budget_ms = budget;
    return r;
  endfunction

  function automatic in_t window(logic op, logic [31:0] now, logic solved,
                                 logic [7:0] boards, logic [14:0] spread, logic integ);
    in_t b;
    b.opcode = op;
    b.now_ms = now;
    b.solved = solved;
    b.board_count = boards;
    b.spread_centideg = spread;
    b.integ_fail = integ;
    return b;
  endfunction

  function automatic void add_row(bit wide, in_t b, bit typed, out_t want);
    row_t r;
    r.wide = wide;
    r.beat = b;
    r.typed = typed;
    r.want = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // health report for one beat; advances the tracked state
  function automatic bit next_health(input in_t b, output out_t r);
    logic [31:0] dt;
    logic [31:0] budget;
    logic [3:0]  why;
    logic [32:0] sum;
    r = NO_REPORT;
    if (b.opcode == OP_RESTART) begin
      track_mode = MODE_UNINIT;
      track_since_fix = '0;
      track_stamp_ok = 1'b0;
      return 1'b0;
    end
    dt = (track_stamp_ok && b.now_ms > track_stamp) ? b.now_ms - track_stamp : '0;
    track_stamp = b.now_ms;
    track_stamp_ok = 1'b1;
    // latched fault holds until restart
    if (track_mode == MODE_FAULT) begin
      r = health(MODE_FAULT, 1'b1, WHY_LATCHED, '0, '0);
      return 1'b1;
    end
    if (b.integ_fail) begin
      track_mode = MODE_FAULT;
      r = health(MODE_FAULT, 1'b1, WHY_INTEGRITY, '0, '0);
      return 1'b1;
    end
    if (b.solved && b.board_count >= track_cfg.min_boards_for_nominal &&
        b.spread_centideg >= track_cfg.min_spread_centideg) begin
      track_mode = MODE_NOMINAL;
      track_since_fix = '0;
      r = health(MODE_NOMINAL, 1'b0, WHY_NOMINAL, '0, '0);
      return 1'b1;
    end
    if (track_mode == MODE_UNINIT && !b.solved) begin
      r = health(MODE_UNINIT, 1'b0, WHY_WAITING, '0, '0);
      return 1'b1;
    end
    // saturating accumulation of time since the last good fix
    sum = {1'b0, track_since_fix} + {1'b0, dt};
    track_since_fix = sum[32] ? '1 : sum[31:0];
    // short empty window keeps the previous mode
    if (!b.solved && track_since_fix <= track_cfg.grace_ms && track_mode != MODE_UNINIT) begin
      r = health(track_mode, 1'b0, WHY_GAP, track_since_fix, '0);
      return 1'b1;
    end
    if (b.solved) begin
      track_mode = MODE_DEGRADED;
      budget = track_cfg.degraded_budget_ms;
      why = (b.board_count < track_cfg.min_boards_for_nominal) ? WHY_ONE_BOARD : WHY_ALIKE;
    end else begin
      track_mode = MODE_DEADRECK;
      budget = track_cfg.dead_reckon_budget_ms;
      why = WHY_NONE;
    end
    if (track_since_fix > budget) begin
      track_mode = MODE_FAULT;
      r = health(MODE_FAULT, 1'b1, WHY_OVER_BUDGET, track_since_fix, budget);
      return 1'b1;
    end
    r = health(track_mode, 1'b0, why, track_since_fix, budget);
    return 1'b1;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one beat, hold it until accepted, then record its report
  task automatic send_beat(input in_t b, input bit typed, input out_t want);
    out_t got;
    bit   has;
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = next_health(b, got);
    if (has) pending_health.insert(pending_health.size(), typed ? want : got);
  endtask

  // random input gap, skipped in quiet stretches
  task automatic maybe_idle(input int idx);
    int n;
    if ((idx / 64) % 3 != 0) begin
      n = pick_gap();
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  // wait until every expected report is out, then let the design settle
  task automatic drain_reports();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_health.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers, plus one unmapped index that must be ignored
  task automatic load_settings(input cfg_t s);
    cfg_we <= 1'b1;
    cfg_index <= REG_DR_BUDGET + CFG_IDX_W'($urandom_range(1, 3));
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_index <= REG_MIN_BOARDS;
    cfg_data <= {27'($urandom), s.min_boards_for_nominal};
    @(posedge clk);
    cfg_index <= REG_MIN_SPREAD;
    cfg_data <= {17'($urandom), s.min_spread_centideg};
    @(posedge clk);
    cfg_index <= REG_GRACE;
    cfg_data <= s.grace_ms;
    @(posedge clk);
    cfg_index <= REG_DEG_BUDGET;
    cfg_data <= s.degraded_budget_ms;
    @(posedge clk);
    cfg_index <= REG_DR_BUDGET;
    cfg_data <= s.dead_reckon_budget_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    track_cfg = s;
  endtask

  // output stall with bursts and quiet stretches
  always @(posedge clk) begin
    if (quiet_left == 0) begin
      stall_quiet = ($urandom_range(0, 3) == 0);
      quiet_left = $urandom_range(20, 200);
    end else begin
      quiet_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_quiet) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_health.size() == 0) begin
        $error("unexpected report: mode %0d reason %0d", out_data.mode, out_data.reason_code);
        fail_count++;
      end else begin
        due_report = pending_health.pop_front();
        if (out_data.mode !== due_report.mode) begin
          $error("mode: expected %0d, got %0d", due_report.mode, out_data.mode);
          fail_count++;
        end
        if (out_data.request_stop !== due_report.request_stop) begin
          $error("request_stop: expected %0d, got %0d",
                 due_report.request_stop, out_data.request_stop);
          fail_count++;
        end
        if (out_data.reason_code !== due_report.reason_code) begin
          $error("reason_code: expected %0d, got %0d",
                 due_report.reason_code, out_data.reason_code);
          fail_count++;
        end
        if (out_data.elapsed_ms !== due_report.elapsed_ms) begin
          $error("elapsed_ms: expected %0d, got %0d", due_report.elapsed_ms, out_data.elapsed_ms);
          fail_count++;
        end
        if (out_data.budget_ms !== due_report.budget_ms) begin
          $error("budget_ms: expected %0d, got %0d", due_report.budget_ms, out_data.budget_ms);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cfg_t s;
    in_t  b;
    int   v;
    bit   wide_loaded;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_BOARDS;
    cfg_data = '0;
    wide_loaded = 1'b0;
    stamp_cursor = '0;
    track_cfg = '{RST_MIN_BOARDS, RST_MIN_SPREAD, RST_GRACE, RST_DEG_BUDGET, RST_DR_BUDGET};
    track_mode = MODE_UNINIT;
    track_stamp = '0;
    track_stamp_ok = 1'b0;
    track_since_fix = '0;

    // directed rows under the reset settings
    add_row(1'b0, window(OP_UPDATE, 32'd100, 1'b0, 8'd0, 15'd0, 1'b0), 1'b1,
            health(MODE_UNINIT, 1'b0, WHY_WAITING, 32'd0, 32'd0));
    add_row(1'b0, window(OP_UPDATE, 32'd200, 1'b1, 8'd1, 15'd2000, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd300, 1'b1, 8'd255, 15'd18000, 1'b0), 1'b1,
            health(MODE_NOMINAL, 1'b0, WHY_NOMINAL, 32'd0, 32'd0));
    add_row(1'b0, window(OP_UPDATE, 32'd600, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    // timestamp going backwards
    add_row(1'b0, window(OP_UPDATE, 32'd500, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd1000, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd1100, 1'b1, 8'd2, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd12000, 1'b1, 8'd3, 15'd100, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd0, 1'b1, 8'd255, 15'd18000, 1'b0), 1'b1,
            health(MODE_FAULT, 1'b1, WHY_LATCHED, 32'd0, 32'd0));
    add_row(1'b0, window(OP_RESTART, 32'hFFFF_FFFF, 1'b1, 8'd255, 15'd18000, 1'b1), 1'b0,
            NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd5, 1'b1, 8'd255, 15'd18000, 1'b1), 1'b1,
            health(MODE_FAULT, 1'b1, WHY_INTEGRITY, 32'd0, 32'd0));
    add_row(1'b0, window(OP_RESTART, 32'd0, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd0, 1'b0, 8'd0, 15'd0, 1'b0), 1'b1,
            health(MODE_UNINIT, 1'b0, WHY_WAITING, 32'd0, 32'd0));
    add_row(1'b0, window(OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_RESTART, 32'd50, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd100, 1'b1, 8'd2, 15'd1500, 1'b0), 1'b1,
            health(MODE_NOMINAL, 1'b0, WHY_NOMINAL, 32'd0, 32'd0));
    add_row(1'b0, window(OP_UPDATE, 32'd300, 1'b1, 8'd2, 15'd1499, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b0, window(OP_UPDATE, 32'd9000, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    // widest settings: saturation of the time since the last fix
    add_row(1'b1, window(OP_RESTART, 32'd0, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b1, window(OP_UPDATE, 32'd0, 1'b1, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b1, window(OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 8'd200, 15'd18000, 1'b0), 1'b0,
            NO_REPORT);
    add_row(1'b1, window(OP_UPDATE, 32'd0, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b1, window(OP_UPDATE, 32'd10, 1'b0, 8'd0, 15'd0, 1'b0), 1'b0, NO_REPORT);
    add_row(1'b1, window(OP_UPDATE, 32'd20, 1'b1, 8'd255, 15'd18000, 1'b1), 1'b1,
            health(MODE_FAULT, 1'b1, WHY_INTEGRITY, 32'd0, 32'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wide && !wide_loaded) begin
        drain_reports();
        load_settings('{5'd31, 15'd32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        wide_loaded = 1'b1;
      end
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      maybe_idle(i + 64);
    end

    // random phases, each under its own settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: s = '{5'd1, 15'd0, 32'd0, 32'd0, 32'd0};
        1: s = '{5'd16, 15'd18000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        default: begin
          case ($urandom_range(0, 5))
            0: s.min_boards_for_nominal = 5'd0;
            1: s.min_boards_for_nominal = 5'd31;
            default: s.min_boards_for_nominal = 5'($urandom_range(1, 16));
          endcase
          s.min_spread_centideg = ($urandom_range(0, 4) == 0) ?
                                  15'($urandom_range(0, 32767)) : 15'($urandom_range(0, 18000));
          s.grace_ms = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2000);
          s.degraded_budget_ms = ($urandom_range(0, 5) == 0) ?
                                 $urandom : $urandom_range(0, 20000);
          s.dead_reckon_budget_ms = ($urandom_range(0, 5) == 0) ?
                                    $urandom : $urandom_range(0, 20000);
        end
      endcase
      drain_reports();
      load_settings(s);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        b.opcode = ($urandom_range(0, 99) < 4) ? OP_RESTART : OP_UPDATE;
        // timestamps mostly move forward in modest steps
        v = $urandom_range(0, 99);
        if (v < 70) stamp_cursor += $urandom_range(0, 600);
        else if (v < 85) stamp_cursor += $urandom_range(600, 4000);
        else if (v < 93) stamp_cursor += $urandom_range(4000, 20000);
        else if (v < 97) stamp_cursor -= $urandom_range(0, 1000);
        else stamp_cursor = $urandom;
        b.now_ms = stamp_cursor;
        b.solved = ($urandom_range(0, 99) < 55);
        // board counts cluster low and around the nominal threshold
        v = $urandom_range(0, 99);
        if (v < 70) b.board_count = 8'($urandom_range(0, 4));
        else if (v < 85) b.board_count = 8'(track_cfg.min_boards_for_nominal) +
                                         8'($urandom_range(0, 2)) - 8'd1;
        else b.board_count = 8'($urandom_range(0, 255));
        v = int'(track_cfg.min_spread_centideg) + int'($urandom_range(0, 400)) - 200;
        if ($urandom_range(0, 1) == 0 || v < 0 || v > 18000) v = $urandom_range(0, 18000);
        b.spread_centideg = 15'(v);
        b.integ_fail = ($urandom_range(0, 99) < 2);
        send_beat(b, 1'b0, NO_REPORT);
        maybe_idle(i);
      end
    end

    drain_reports();
    if (pending_health.size() != 0) begin
      $error("%0d expected reports never arrived", pending_health.size());
    end
    if (fail_count == 0 && pending_health.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lhms_pkg.sv
rtl/lhms_update.sv
rtl/localization_health_mode_supervisor.sv
tb/sv/localization_health_mode_supervisor_tb.sv
